// File: rtl/mouse_report_encoder_core_macros.svh
// Assertion macros for the mouse report encoder RTL.
`ifndef MOUSE_REPORT_ENCODER_CORE_MACROS_SVH
`define MOUSE_REPORT_ENCODER_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MRE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mre_pkg.sv
// Types, codes and constants shared by the mouse report encoder modules.
`default_nettype none

package mre_pkg;

	// Field widths of the event and report beats.
	localparam int unsigned KIND_W        = 2;
	localparam int unsigned BUTTON_W      = 4;
	localparam int unsigned COORD_FIELD_W = 12;
	localparam int unsigned MODS_W        = 3;
	localparam int unsigned CODE_W        = 8;
	localparam int unsigned BYTE_W        = 8;

	// Width of the decimal weight table entries (nine times a thousand fits).
	localparam int unsigned WEIGHT_W = 14;

	// Depth of the queue between front and back; a power of two.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Event kinds.
	localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MOTION  = 2'd2;

	// The button number whose base code always takes the release code.
	localparam logic [BUTTON_W-1:0] BUTTON_FORCED_RELEASE = 4'd12;

	// Modifier bit positions.
	localparam int unsigned MOD_SHIFT = 0;
	localparam int unsigned MOD_ALT   = 1;
	localparam int unsigned MOD_CTRL  = 2;

	// Button code offsets.
	localparam logic [CODE_W-1:0] CODE_MOTION  = 8'd32;
	localparam logic [CODE_W-1:0] CODE_RELEASE = 8'd3;
	localparam logic [CODE_W-1:0] CODE_SHIFT   = 8'd4;
	localparam logic [CODE_W-1:0] CODE_ALT     = 8'd8;
	localparam logic [CODE_W-1:0] CODE_CTRL    = 8'd16;

	// Legacy reports carry each value offset by a space.
	localparam logic [BYTE_W-1:0] LEGACY_OFFSET    = 8'd32;
	localparam logic [COORD_FIELD_W-1:0] LEGACY_COORD_MAX = 12'd223;

	// Characters of the escape sequences.
	localparam logic [BYTE_W-1:0] CH_ESC     = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_BRACKET = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_LESS    = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_UPPER_M = 8'h4D;
	localparam logic [BYTE_W-1:0] CH_LOWER_M = 8'h6D;
	localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;

	// One mouse event as it enters the block.
	typedef struct packed {
		logic [KIND_W-1:0]        event_kind;
		logic [BUTTON_W-1:0]      button;
		logic [COORD_FIELD_W-1:0] col;
		logic [COORD_FIELD_W-1:0] row;
		logic [MODS_W-1:0]        modifiers;
	} mouse_event_t;

	// One byte of a report as it leaves the block.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} report_t;

	// A classified event waiting to be written out.
	typedef struct packed {
		logic                     sgr;
		logic                     release_evt;
		logic [CODE_W-1:0]        code;
		logic [COORD_FIELD_W-1:0] col;
		logic [COORD_FIELD_W-1:0] row;
	} job_t;

	// Number being written out in SGR mode.
	typedef enum logic [1:0] {
		FLD_CODE,
		FLD_COL,
		FLD_ROW
	} field_t;

	// Byte sequencer states of the back end.
	typedef enum logic [3:0] {
		BK_IDLE,
		BK_ESC,
		BK_BRK,
		BK_INTRO,
		BK_LCODE,
		BK_LCOL,
		BK_LROW,
		BK_DIGITS,
		BK_SEP,
		BK_FINAL
	} back_state_t;

	// Decimal weight of digit position k.
	function automatic logic [WEIGHT_W-1:0] dec_weight(input logic [1:0] k);
		logic [WEIGHT_W-1:0] w;
		case (k)
			2'd0: w = 14'd1;
			2'd1: w = 14'd10;
			2'd2: w = 14'd100;
			2'd3: w = 14'd1000;
			default: w = 14'd1;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mouse_report_encoder_core.sv
// Top level of the mouse report encoder: front end, event queue and back end.
//
// Usage:
// - Events enter on mouse_event with push; a beat is taken at a clock edge
//   with push high and full low. Events with a zero coordinate, or with a
//   coordinate above 223 in legacy mode, are taken and report nothing.
// - Report bytes leave on report while empty is low; pop takes the byte.
//   report.last marks the final byte of each report.
// - cfg_wr_en with cfg_wr_data selects the format: 1 for SGR decimal,
//   0 for the legacy six-byte form. Write it only while the block is idle.
// - The first byte of a report becomes visible once its event has passed
//   the event queue, the job register and the output register.
// - One byte per cycle while the receiver keeps up; a legacy report has six
//   bytes, an SGR report 9 to 17 bytes. Reports follow each other back to
//   back while events are queued.
// - A two-entry event queue lets the front keep taking events while the
//   back end writes bytes; full rises when it holds two waiting events.
// - When the receiver stalls, the byte waits in the output register and the
//   sequencer holds; once the queue fills, full holds off new events.
// - Reset clears the queue, the sequencer and the valid flag of the output
//   register and sets the legacy format.
`default_nettype none

module mouse_report_encoder_core import mre_pkg::*; #(
	parameter int unsigned COORD_WIDTH = 12
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_wr_data,
	input  wire logic         push,
	output logic              full,
	input  wire mouse_event_t mouse_event,
	input  wire logic         pop,
	output logic              empty,
	output report_t           report
);

	// Coordinate bits that can reach the report.
	localparam int unsigned VW = (COORD_WIDTH < COORD_FIELD_W) ? COORD_WIDTH : COORD_FIELD_W;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_push_job;
	job_t q_pop_job;

	mre_front #(
		.VW(VW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push       (push),
		.full       (full),
		.mouse_event(mouse_event),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (q_push_job)
	);

	mre_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(q_push_job),
		.full    (q_full),
		.pop     (q_pop),
		.pop_job (q_pop_job),
		.empty   (q_empty)
	);

	mre_back #(
		.VW(VW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_job  (q_pop_job),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.report (report)
	);

endmodule

`default_nettype wire

// File: rtl/mre_front.sv
// Front end: holds the mode register, classifies events and builds the button code.
`default_nettype none

module mre_front import mre_pkg::*; #(
	parameter int unsigned VW = 12
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_wr_data,
	input  wire logic         push,
	output logic              full,
	input  wire mouse_event_t mouse_event,
	input  wire logic         q_full,
	output logic              q_push,
	output job_t              q_job
);

	logic              fmt_sgr_q;
	logic [VW-1:0]     col_v;
	logic [VW-1:0]     row_v;
	logic [CODE_W-1:0] code;
	logic [CODE_W-1:0] base;
	logic              coords_ok;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_sgr_q <= 1'b0;
		end else if (cfg_wr_en) begin
			fmt_sgr_q <= cfg_wr_data;
		end
	end

	// Only the low coordinate bits take part.
	assign col_v = VW'(mouse_event.col);
	assign row_v = VW'(mouse_event.row);

	// Button code from kind, button number and modifiers.
	always_comb begin
		case (mouse_event.button) inside
			[4'd8:4'd15]: base = 8'(mouse_event.button) + 8'd120;
			[4'd4:4'd7]:  base = 8'(mouse_event.button) + 8'd60;
			[4'd1:4'd3]:  base = 8'(mouse_event.button) - 8'd1;
			default:      base = '0;
		endcase
		if ((!fmt_sgr_q && mouse_event.event_kind == KIND_RELEASE) ||
				mouse_event.button == BUTTON_FORCED_RELEASE) begin
			base = CODE_RELEASE;
		end
		code = base;
		if (mouse_event.event_kind == KIND_MOTION) begin
			code = code + CODE_MOTION;
		end
		if (mouse_event.modifiers[MOD_SHIFT]) begin
			code = code + CODE_SHIFT;
		end
		if (mouse_event.modifiers[MOD_ALT]) begin
			code = code + CODE_ALT;
		end
		if (mouse_event.modifiers[MOD_CTRL]) begin
			code = code + CODE_CTRL;
		end
	end

	// Positions off the grid, or beyond the legacy range, report nothing.
	always_comb begin
		coords_ok = (col_v != '0) && (row_v != '0);
		if (!fmt_sgr_q && (COORD_FIELD_W'(col_v) > LEGACY_COORD_MAX ||
				COORD_FIELD_W'(row_v) > LEGACY_COORD_MAX)) begin
			coords_ok = 1'b0;
		end
	end

	// Accepted events that report something go to the queue.
	assign full   = q_full;
	assign q_push = push && !q_full && coords_ok;

	always_comb begin
		q_job.sgr         = fmt_sgr_q;
		q_job.release_evt = (mouse_event.event_kind == KIND_RELEASE);
		q_job.code        = code;
		q_job.col         = COORD_FIELD_W'(col_v);
		q_job.row         = COORD_FIELD_W'(row_v);
	end

endmodule

`default_nettype wire

// File: rtl/mre_queue.sv
// Short queue of classified events between the front and back ends.
`default_nettype none

module mre_queue import mre_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output job_t      pop_job,
	output logic      empty
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	// Pointers and fill count; pointers wrap since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// File: rtl/mre_back.sv
// Back end: turns one queued event into report bytes, one byte per cycle while the receiver takes them.
`default_nettype none

module mre_back import mre_pkg::*; #(
	parameter int unsigned VW = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire job_t q_job,
	output logic      q_pop,
	input  wire logic pop,
	output logic      empty,
	output report_t   report
);

	`include "mouse_report_encoder_core_macros.svh"

	// Decimal digits needed for the widest number written.
	localparam int unsigned ND = (VW <= 9) ? 3 : 4;

	back_state_t         state_q, state_d;
	job_t                job_q;
	logic [VW-1:0]       val_q, val_d;
	logic [1:0]          pidx_q, pidx_d;
	field_t              fld_q, fld_d;
	logic                out_valid_q;
	report_t             out_q;

	logic                out_ready;
	logic                emit;
	logic                load_job;
	logic                load_val;
	logic                last_byte;
	logic [BYTE_W-1:0]   byte_d;
	logic [VW-1:0]       sel_val;
	logic [1:0]          sel_pidx;
	logic [WEIGHT_W-1:0] w;
	logic [WEIGHT_W-1:0] sub;
	logic [3:0]          digit;

	assign out_ready = !out_valid_q || pop;
	assign emit      = (state_q != BK_IDLE) && out_ready;

	// Current decimal digit: count the multiples of the weight that fit.
	always_comb begin
		w     = dec_weight(pidx_q);
		digit = '0;
		sub   = '0;
		for (int d = 1; d <= 9; d++) begin
			if (WEIGHT_W'(val_q) >= WEIGHT_W'(d) * w) begin
				digit = 4'(d);
				sub   = WEIGHT_W'(d) * w;
			end
		end
	end

	// Number to write next and its leading digit position.
	always_comb begin
		if (state_q == BK_INTRO) begin
			sel_val = VW'(job_q.code);
		end else if (fld_q == FLD_CODE) begin
			sel_val = VW'(job_q.col);
		end else begin
			sel_val = VW'(job_q.row);
		end
		sel_pidx = '0;
		for (int k = 1; k < ND; k++) begin
			if (WEIGHT_W'(sel_val) >= dec_weight(2'(k))) begin
				sel_pidx = 2'(k);
			end
		end
	end

	// Byte sequencer.
	always_comb begin
		state_d   = state_q;
		byte_d    = CH_ESC;
		last_byte = 1'b0;
		val_d     = val_q;
		pidx_d    = pidx_q;
		fld_d     = fld_q;
		load_val  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				state_d = BK_IDLE;
			end
			BK_ESC: begin
				byte_d = CH_ESC;
				if (emit) state_d = BK_BRK;
			end
			BK_BRK: begin
				byte_d = CH_BRACKET;
				if (emit) state_d = BK_INTRO;
			end
			BK_INTRO: begin
				byte_d = job_q.sgr ? CH_LESS : CH_UPPER_M;
				if (emit) begin
					if (job_q.sgr) begin
						state_d  = BK_DIGITS;
						fld_d    = FLD_CODE;
						load_val = 1'b1;
					end else begin
						state_d = BK_LCODE;
					end
				end
			end
			BK_LCODE: begin
				byte_d = job_q.code + LEGACY_OFFSET;
				if (emit) state_d = BK_LCOL;
			end
			BK_LCOL: begin
				byte_d = BYTE_W'(job_q.col) + LEGACY_OFFSET;
				if (emit) state_d = BK_LROW;
			end
			BK_LROW: begin
				byte_d    = BYTE_W'(job_q.row) + LEGACY_OFFSET;
				last_byte = 1'b1;
			end
			BK_DIGITS: begin
				byte_d = CH_ZERO + BYTE_W'(digit);
				if (emit) begin
					val_d = VW'(WEIGHT_W'(val_q) - sub);
					if (pidx_q == '0) begin
						state_d = (fld_q == FLD_ROW) ? BK_FINAL : BK_SEP;
					end else begin
						pidx_d = pidx_q - 1'b1;
					end
				end
			end
			BK_SEP: begin
				byte_d = CH_SEMI;
				if (emit) begin
					fld_d    = (fld_q == FLD_CODE) ? FLD_COL : FLD_ROW;
					load_val = 1'b1;
					state_d  = BK_DIGITS;
				end
			end
			BK_FINAL: begin
				byte_d    = job_q.release_evt ? CH_LOWER_M : CH_UPPER_M;
				last_byte = 1'b1;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
		if (load_val) begin
			val_d  = sel_val;
			pidx_d = sel_pidx;
		end
		// The next event starts right behind the last byte of this one.
		load_job = !q_empty && ((state_q == BK_IDLE) || (emit && last_byte));
		if (load_job) begin
			state_d = BK_ESC;
		end else if (emit && last_byte) begin
			state_d = BK_IDLE;
		end
	end

	assign q_pop = load_job;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ready) begin
				out_valid_q <= emit;
			end
		end
	end

	// Working and output data registers.
	always_ff @(posedge clk) begin
		val_q  <= val_d;
		pidx_q <= pidx_d;
		fld_q  <= fld_d;
		if (load_job) begin
			job_q <= q_job;
		end
		if (emit) begin
			out_q.out_byte <= byte_d;
			out_q.last     <= last_byte;
		end
	end

	assign empty  = !out_valid_q;
	assign report = out_q;

	// A pop only takes an entry that is there.
	`MRE_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "queue popped while empty")
	// The digit position never starts above the number's width.
	`MRE_ASSERT_NOW(a_pidx_range, state_q == BK_DIGITS, 32'(pidx_q) < ND,
		"digit position out of range")
	// The remaining value always fits below the next decimal weight.
	`MRE_ASSERT_NOW(a_digit_fits, state_q == BK_DIGITS,
		32'(val_q) < 32'(w) * 10, "decimal value exceeds its digit count")
	// The closing byte of a report carries the last mark.
	`MRE_ASSERT_NEXT(a_last_mark, emit && (state_q == BK_FINAL || state_q == BK_LROW),
		out_q.last, "final byte lost its last mark")

endmodule

`default_nettype wire
